FILE: design/tree_path_via_common_ancestor_unit_assert.svh
// Assertion macros shared by the tree path unit
`ifndef TREE_PATH_VIA_COMMON_ANCESTOR_UNIT_ASSERT_SVH
`define TREE_PATH_VIA_COMMON_ANCESTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define TPCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpca assertion failed");

// Next-cycle implication, checked out of reset
`define TPCA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpca assertion failed");

`endif

FILE: design/tpca_pkg.sv
// Types and constants of the tree path unit
package tpca_pkg;

    localparam int NODES    = 32;
    localparam int NODE_W   = 5;
    localparam int CNT_W    = $clog2(NODES + 1);
    localparam int STACK_AW = NODE_W + 1;
    localparam int REM_W    = $clog2(2 * NODES + 2);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LINK  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACK,
        ST_ERR,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_STRIP_RD,
        ST_STRIP_CHK,
        ST_EMIT_RD,
        ST_EMIT_PUSH
    } state_t;

    typedef enum logic [1:0] {
        PART_SRC,
        PART_ROOT,
        PART_DST
    } part_t;

    typedef struct packed {
        logic              clear;
        logic              link_we;
        logic [NODE_W-1:0] child;
        logic [NODE_W-1:0] parent;
    } pt_cmd_t;

    typedef struct packed {
        logic              has_parent;
        logic [NODE_W-1:0] parent;
    } pt_rsp_t;

    typedef struct packed {
        logic [NODE_W-1:0] path_node;
        logic              last;
        logic              error;
    } result_t;

endpackage

FILE: design/tpca_req_if.sv
// Request channel: one operation item
interface tpca_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [tpca_pkg::NODE_W-1:0] node_a;
    logic [tpca_pkg::NODE_W-1:0] node_b;

    modport source (output valid, output op, output node_a, output node_b, input ready);
    modport sink   (input valid, input op, input node_a, input node_b, output ready);
endinterface

FILE: design/tpca_rsp_if.sv
// Response channel: one path node item
interface tpca_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [tpca_pkg::NODE_W-1:0] path_node;
    logic                       last;
    logic                       error;

    modport source (output valid, output path_node, output last, output error, input ready);
    modport sink   (input valid, input path_node, input last, input error, output ready);
endinterface

FILE: design/tpca_parent_table.sv
// Parent pointer table: valid flags in flops, parent indices in a synchronous memory
module tpca_parent_table
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tpca_pkg::pt_cmd_t            cmd,
    input  logic [tpca_pkg::NODE_W-1:0]  rd_addr,
    output tpca_pkg::pt_rsp_t            rd_rsp
);

    logic                        valid_reg [tpca_pkg::NODES];
    logic [tpca_pkg::NODE_W-1:0] parent_mem [tpca_pkg::NODES];
    logic                        rd_valid_reg;
    logic [tpca_pkg::NODE_W-1:0] rd_parent_reg;

    // Valid flags: clear wipes all entries at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tpca_pkg::NODES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < tpca_pkg::NODES; i++)
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
            else if (cmd.link_we)
            begin
                valid_reg[cmd.child] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.link_we)
        begin
            parent_mem[cmd.child] <= cmd.parent;
        end
        rd_parent_reg <= parent_mem[rd_addr];
    end

    assign rd_rsp.has_parent = rd_valid_reg;
    assign rd_rsp.parent     = rd_parent_reg;

endmodule

FILE: design/tpca_out_fifo.sv
// Two-entry result buffer between the sequencer and the response channel
module tpca_out_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  tpca_pkg::result_t   push_item,
    output logic                push_ready,
    tpca_rsp_if.source          rsp
);

    tpca_pkg::result_t mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = rsp.valid && rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign rsp.valid     = (count_reg != 2'd0);
    assign rsp.path_node = mem_reg[rd_ptr_reg].path_node;
    assign rsp.last      = mem_reg[rd_ptr_reg].last;
    assign rsp.error     = mem_reg[rd_ptr_reg].error;

endmodule

FILE: design/tpca_ctrl.sv
// Sequencer: table updates, ancestor walks into the path stack, suffix strip, emission
`include "tree_path_via_common_ancestor_unit_assert.svh"

module tpca_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    tpca_req_if.sink                     req,
    output tpca_pkg::pt_cmd_t            pt_cmd,
    output logic [tpca_pkg::NODE_W-1:0]  pt_rd_addr,
    input  tpca_pkg::pt_rsp_t            pt_rsp,
    output logic                         push_valid,
    output tpca_pkg::result_t            push_item,
    input  logic                         push_ready
);

    tpca_pkg::state_t              state_reg, state_next;
    tpca_pkg::part_t               part_reg, part_next;
    logic                          side_reg, side_next;
    logic [tpca_pkg::NODE_W-1:0]   cur_reg, cur_next;
    logic [tpca_pkg::NODE_W-1:0]   dst_reg, dst_next;
    logic [tpca_pkg::CNT_W-1:0]    n_reg, n_next;
    logic [tpca_pkg::CNT_W-1:0]    la_reg, la_next;
    logic [tpca_pkg::CNT_W-1:0]    lb_reg, lb_next;
    logic [tpca_pkg::NODE_W-1:0]   root_reg, root_next;
    logic                          have_root_reg, have_root_next;
    logic [tpca_pkg::NODE_W-1:0]   idx_reg, idx_next;
    logic [tpca_pkg::REM_W-1:0]    rem_reg, rem_next;

    // Path stack: lower half holds the source chain, upper half the destination chain
    logic [tpca_pkg::NODE_W-1:0]   stack_mem [2**tpca_pkg::STACK_AW];
    logic                          st_we;
    logic [tpca_pkg::STACK_AW-1:0] st_waddr;
    logic                          st_rd_en;
    logic [tpca_pkg::NODE_W-1:0]   rd_idx0;
    logic [tpca_pkg::NODE_W-1:0]   rd_idx1;
    logic [tpca_pkg::NODE_W-1:0]   rd0_reg;
    logic [tpca_pkg::NODE_W-1:0]   rd1_reg;

    logic [tpca_pkg::NODE_W-1:0]   la_m1;
    logic [tpca_pkg::NODE_W-1:0]   lb_m1;
    logic [tpca_pkg::REM_W-1:0]    total;
    logic                          link_in_range;

    assign la_m1 = la_reg[tpca_pkg::NODE_W-1:0] - 1'b1;
    assign lb_m1 = lb_reg[tpca_pkg::NODE_W-1:0] - 1'b1;
    assign total = tpca_pkg::REM_W'(la_reg) + tpca_pkg::REM_W'(have_root_reg)
                 + tpca_pkg::REM_W'(lb_reg);
    assign link_in_range =
        (tpca_pkg::CNT_W'(req.node_a) < tpca_pkg::CNT_W'(tpca_pkg::NODES)) &&
        (tpca_pkg::CNT_W'(req.node_b) < tpca_pkg::CNT_W'(tpca_pkg::NODES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpca_pkg::ST_IDLE;
            part_reg      <= tpca_pkg::PART_SRC;
            side_reg      <= 1'b0;
            n_reg         <= '0;
            la_reg        <= '0;
            lb_reg        <= '0;
            have_root_reg <= 1'b0;
            idx_reg       <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            part_reg      <= part_next;
            side_reg      <= side_next;
            n_reg         <= n_next;
            la_reg        <= la_next;
            lb_reg        <= lb_next;
            have_root_reg <= have_root_next;
            idx_reg       <= idx_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        dst_reg  <= dst_next;
        root_reg <= root_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stack_mem[st_waddr] <= cur_reg;
        end
        if (st_rd_en)
        begin
            rd0_reg <= stack_mem[{1'b0, rd_idx0}];
            rd1_reg <= stack_mem[{1'b1, rd_idx1}];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        part_next      = part_reg;
        side_next      = side_reg;
        cur_next       = cur_reg;
        dst_next       = dst_reg;
        n_next         = n_reg;
        la_next        = la_reg;
        lb_next        = lb_reg;
        root_next      = root_reg;
        have_root_next = have_root_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;

        req.ready      = 1'b0;
        pt_cmd         = '0;
        pt_rd_addr     = cur_reg;
        st_we          = 1'b0;
        st_waddr       = {side_reg, n_reg[tpca_pkg::NODE_W-1:0]};
        st_rd_en       = 1'b0;
        rd_idx0        = idx_reg;
        rd_idx1        = idx_reg;
        push_valid     = 1'b0;
        push_item      = '0;

        unique case (state_reg)
            tpca_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    unique case (tpca_pkg::op_t'(req.op))
                        tpca_pkg::OP_CLEAR:
                        begin
                            pt_cmd.clear = 1'b1;
                            state_next   = tpca_pkg::ST_ACK;
                        end
                        tpca_pkg::OP_LINK:
                        begin
                            pt_cmd.link_we = link_in_range;
                            pt_cmd.child   = req.node_a;
                            pt_cmd.parent  = req.node_b;
                            state_next     = tpca_pkg::ST_ACK;
                        end
                        tpca_pkg::OP_QUERY:
                        begin
                            cur_next   = req.node_a;
                            dst_next   = req.node_b;
                            side_next  = 1'b0;
                            n_next     = '0;
                            state_next = tpca_pkg::ST_WALK_RD;
                        end
                        default:
                        begin
                            state_next = tpca_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            tpca_pkg::ST_ACK, tpca_pkg::ST_ERR:
            begin
                push_valid      = 1'b1;
                push_item.last  = 1'b1;
                push_item.error = (state_reg == tpca_pkg::ST_ERR);
                if (push_ready)
                begin
                    state_next = tpca_pkg::ST_IDLE;
                end
            end

            tpca_pkg::ST_WALK_RD:
            begin
                // Record the current node and fetch its parent entry
                st_we      = 1'b1;
                n_next     = n_reg + 1'b1;
                state_next = tpca_pkg::ST_WALK_CHK;
            end

            tpca_pkg::ST_WALK_CHK:
            begin
                if (!pt_rsp.has_parent)
                begin
                    if (!side_reg)
                    begin
                        la_next    = n_reg;
                        side_next  = 1'b1;
                        cur_next   = dst_reg;
                        n_next     = '0;
                        state_next = tpca_pkg::ST_WALK_RD;
                    end
                    else
                    begin
                        lb_next        = n_reg;
                        have_root_next = 1'b0;
                        state_next     = tpca_pkg::ST_STRIP_RD;
                    end
                end
                else if (n_reg >= tpca_pkg::CNT_W'(tpca_pkg::NODES))
                begin
                    state_next = tpca_pkg::ST_ERR;
                end
                else
                begin
                    cur_next   = pt_rsp.parent;
                    state_next = tpca_pkg::ST_WALK_RD;
                end
            end

            tpca_pkg::ST_STRIP_RD, tpca_pkg::ST_STRIP_CHK:
            begin
                rd_idx0 = la_m1;
                rd_idx1 = lb_m1;
                if (state_reg == tpca_pkg::ST_STRIP_CHK && rd0_reg == rd1_reg)
                begin
                    // Shared ancestor: drop it from both chains
                    root_next      = rd0_reg;
                    have_root_next = 1'b1;
                    la_next        = la_reg - 1'b1;
                    lb_next        = lb_reg - 1'b1;
                    state_next     = tpca_pkg::ST_STRIP_RD;
                end
                else if (state_reg == tpca_pkg::ST_STRIP_RD && la_reg != '0 && lb_reg != '0)
                begin
                    st_rd_en   = 1'b1;
                    state_next = tpca_pkg::ST_STRIP_CHK;
                end
                else
                begin
                    rem_next   = total;
                    state_next = tpca_pkg::ST_EMIT_RD;
                    if (la_reg != '0)
                    begin
                        part_next = tpca_pkg::PART_SRC;
                        idx_next  = '0;
                    end
                    else if (have_root_reg)
                    begin
                        part_next = tpca_pkg::PART_ROOT;
                    end
                    else
                    begin
                        part_next = tpca_pkg::PART_DST;
                        idx_next  = lb_m1;
                    end
                end
            end

            tpca_pkg::ST_EMIT_RD:
            begin
                st_rd_en   = 1'b1;
                state_next = tpca_pkg::ST_EMIT_PUSH;
            end

            tpca_pkg::ST_EMIT_PUSH:
            begin
                push_valid     = 1'b1;
                push_item.last = (rem_reg == tpca_pkg::REM_W'(1));
                unique case (part_reg)
                    tpca_pkg::PART_SRC:  push_item.path_node = rd0_reg;
                    tpca_pkg::PART_ROOT: push_item.path_node = root_reg;
                    default:             push_item.path_node = rd1_reg;
                endcase
                if (push_ready)
                begin
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == tpca_pkg::REM_W'(1))
                    begin
                        state_next = tpca_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = tpca_pkg::ST_EMIT_RD;
                        unique case (part_reg)
                            tpca_pkg::PART_SRC:
                            begin
                                if (tpca_pkg::CNT_W'(idx_reg) + 1'b1 == la_reg)
                                begin
                                    if (have_root_reg)
                                    begin
                                        part_next = tpca_pkg::PART_ROOT;
                                    end
                                    else
                                    begin
                                        part_next = tpca_pkg::PART_DST;
                                        idx_next  = lb_m1;
                                    end
                                end
                                else
                                begin
                                    idx_next = idx_reg + 1'b1;
                                end
                            end
                            tpca_pkg::PART_ROOT:
                            begin
                                part_next = tpca_pkg::PART_DST;
                                idx_next  = lb_m1;
                            end
                            default:
                            begin
                                idx_next = idx_reg - 1'b1;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = tpca_pkg::ST_IDLE;
            end
        endcase
    end

    // A final item always returns the sequencer to idle
    `TPCA_ASSERT_NXT(a_last_ends_item, clk, rst_n,
        push_valid && push_ready && push_item.last, state_reg == tpca_pkg::ST_IDLE)
    // Emission never runs with an exhausted count
    `TPCA_ASSERT_IMP(a_rem_nonzero, clk, rst_n,
        state_reg == tpca_pkg::ST_EMIT_RD || state_reg == tpca_pkg::ST_EMIT_PUSH,
        rem_reg != '0)
    // Stack writes stay inside one chain's half
    `TPCA_ASSERT_IMP(a_walk_bound, clk, rst_n,
        state_reg == tpca_pkg::ST_WALK_RD, n_reg < tpca_pkg::CNT_W'(tpca_pkg::NODES))
    // Requests are taken only between items
    `TPCA_ASSERT_IMP(a_ready_idle, clk, rst_n,
        req.ready, state_reg == tpca_pkg::ST_IDLE)

endmodule

FILE: design/tree_path_via_common_ancestor_unit.sv
// Clear and link: the acknowledgement item passes from the ACK state through the result buffer to rsp;
// the next request is taken once the sequencer is back in idle.
// Query: each ancestor walk step, each shared ancestor stripped and each result item takes a read
// state and a check or push state (WALK_RD/WALK_CHK, STRIP_RD/STRIP_CHK, EMIT_RD/EMIT_PUSH), since
// the memories read through a register; a result push waits while the buffer is full.
// Reset: parent table empty (all valid flags cleared), sequencer idle, result buffer empty.
module tree_path_via_common_ancestor_unit
(
    input  logic       clk,
    input  logic       rst_n,
    tpca_req_if.sink   req,
    tpca_rsp_if.source rsp
);

    // Sequencer to parent table
    tpca_pkg::pt_cmd_t           pt_cmd;
    logic [tpca_pkg::NODE_W-1:0] pt_rd_addr;
    tpca_pkg::pt_rsp_t           pt_rsp;

    // Sequencer to result buffer; the buffer lets a new item in while results wait
    logic                        push_valid;
    tpca_pkg::result_t           push_item;
    logic                        push_ready;

    // Hold parent pointers; clear drops every valid flag at once
    tpca_parent_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (pt_cmd),
        .rd_addr (pt_rd_addr),
        .rd_rsp  (pt_rsp)
    );

    // Walk both chains into the path stack, strip the shared top, emit the path
    tpca_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .pt_cmd     (pt_cmd),
        .pt_rd_addr (pt_rd_addr),
        .pt_rsp     (pt_rsp),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    // Hold result items until the consumer takes them
    tpca_out_fifo u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .rsp        (rsp)
    );

endmodule
